// ----- rtl/assert_macros.svh -----
// Assertion macros used by the budget fitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`endif

// ----- rtl/gpbf_pkg.sv -----
// Package with shared sizes, codes and role tables of the budget fitter.
package gpbf_pkg;
    localparam int MaxEntries = 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = IdxW + 1;

    localparam logic [1:0] SchF32 = 2'd0;
    localparam logic [1:0] SchQ8 = 2'd1;
    localparam logic [1:0] SchQ4 = 2'd2;

    localparam logic [2:0] RoleEmb = 3'd0;
    localparam logic [2:0] RoleAtt = 3'd1;
    localparam logic [2:0] RoleMlp = 3'd2;
    localparam logic [2:0] RoleOut = 3'd3;
    localparam logic [2:0] RoleNorm = 3'd4;
    localparam logic [2:0] RoleOther = 3'd5;

    localparam logic [2:0] RegBudget = 3'd0;

    function automatic logic scheme_permitted(input logic [2:0] role, input logic [1:0] s);
        logic r;
        begin
            if (s == SchF32) r = 1'b1;
            else if (s == SchQ8) r = (role != RoleNorm);
            else r = (role == RoleAtt) || (role == RoleMlp) || (role == RoleOther);
            return r;
        end
    endfunction

    function automatic logic [1:0] default_for_role(input logic [2:0] role);
        logic [1:0] r;
        begin
            if (role == RoleEmb || role == RoleAtt || role == RoleOut) r = SchQ8;
            else if (role == RoleMlp) r = SchQ4;
            else r = SchF32;
            return r;
        end
    endfunction

    function automatic logic [1:0] cheapest_for_role(input logic [2:0] role);
        logic [1:0] r;
        begin
            if (role == RoleNorm) r = SchF32;
            else if (role == RoleEmb || role == RoleOut) r = SchQ8;
            else r = SchQ4;
            return r;
        end
    endfunction
endpackage

// ----- rtl/gpbf_infer.sv -----
// Scheme inference and size selection for one loaded tensor.
module gpbf_infer import gpbf_pkg::*; (
    input  logic [2:0]  tensor_role,
    input  logic [47:0] stored_bytes,
    input  logic [45:0] element_count,
    input  logic [1:0]  ir_quant,
    input  logic [47:0] bytes_q8,
    input  logic [47:0] bytes_q4,
    output logic [2:0]  role,
    output logic [1:0]  scheme,
    output logic [47:0] size_f32,
    output logic [47:0] size_min
);
    logic [1:0] cheap;

    always_comb begin
        role = (tensor_role > RoleOther) ? RoleOther : tensor_role;
        size_f32 = {element_count, 2'b00};
        if (ir_quant == 2'd2) begin
            scheme = SchQ4;
        end else if (ir_quant == 2'd1) begin
            scheme = SchQ8;
        end else if (element_count != '0 && stored_bytes < size_f32) begin
            if (stored_bytes == bytes_q4) scheme = SchQ4;
            else if (stored_bytes == bytes_q8) scheme = SchQ8;
            else if (stored_bytes <= {2'b00, element_count}) scheme = SchQ4;
            else scheme = SchQ8;
        end else begin
            scheme = SchF32;
        end
        cheap = cheapest_for_role(role);
        case (cheap)
            SchF32:  size_min = size_f32;
            SchQ8:   size_min = bytes_q8;
            default: size_min = bytes_q4;
        endcase
    end
endmodule

// ----- rtl/greedy_precision_budget_fitter.sv -----
// Loads are accepted while idle. A plan transfer first forms the starting total of the loaded
// tensors, then makes downgrades (at most 128 downgrades) while over budget, one per scan of
// all entries, ending early when a scan finds none, and then sends one result per tensor while
// the receiver is ready. The input is not ready from the plan transfer until the last result
// is registered. The entry memory has a single read port, so entries are read one at a time.
`include "assert_macros.svh"
module greedy_precision_budget_fitter import gpbf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [2:0]  s_tensor_role,
    input  logic [47:0] s_stored_bytes,
    input  logic [45:0] s_element_count,
    input  logic [1:0]  s_ir_quant,
    input  logic [47:0] s_bytes_q8,
    input  logic [47:0] s_bytes_q4,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_tensor_index,
    output logic [1:0]  m_current_scheme,
    output logic [1:0]  m_chosen_scheme,
    output logic [63:0] m_planned_bytes,
    output logic [63:0] m_current_total,
    output logic [63:0] m_minimum_total,
    output logic        m_feasible,
    output logic        m_last
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SUM, ST_CHECK, ST_SCAN, ST_APPLY, ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]  role;
        logic [47:0] f32;
        logic [47:0] q8;
        logic [47:0] q4;
        logic [1:0]  cur;
    } entry_t;

    entry_t     mem [MaxEntries];
    logic [1:0] chosen_mem [MaxEntries];

    state_t         state_reg;
    logic [47:0]    budget_reg;
    logic [CntW-1:0] count_reg;
    logic [63:0]    cur_total_reg, min_total_reg, total_reg;
    logic [CntW-1:0] ptr_reg;
    logic           rd_valid_reg;
    logic [IdxW-1:0] rd_idx_reg;
    entry_t         rd_reg;
    logic [1:0]     rd_ch_reg;
    logic [63:0]    best_gain_reg;
    logic [IdxW-1:0] best_idx_reg;
    logic           best_found_reg;
    logic [1:0]     best_ch_reg;
    logic [7:0]     steps_reg;
    logic           ok_reg;
    logic           m_valid_reg;
    logic [5:0]     m_idx_reg;
    logic [1:0]     m_cur_reg, m_ch_reg;
    logic           m_last_reg;
    logic [63:0]    m_plan_reg, m_curt_reg, m_mint_reg;
    logic           m_feas_reg;

    logic [2:0]  ld_role;
    logic [1:0]  ld_sch;
    logic [47:0] ld_f32, ld_min;

    gpbf_infer u_infer (
        .tensor_role(s_tensor_role), .stored_bytes(s_stored_bytes),
        .element_count(s_element_count), .ir_quant(s_ir_quant),
        .bytes_q8(s_bytes_q8), .bytes_q4(s_bytes_q4),
        .role(ld_role), .scheme(ld_sch), .size_f32(ld_f32), .size_min(ld_min)
    );

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == RegBudget) ? {16'd0, budget_reg} : '0;

    assign s_ready = (state_reg == ST_IDLE);

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // Read entry's size at chosen, next and start scheme (default if no budget, else current).
    logic [47:0] sz_ch, sz_nx, sz_use;
    logic [1:0]  dflt_ch, use_ch;
    logic        can_dn;
    logic [63:0] save;
    always_comb begin
        case (rd_ch_reg)
            SchF32:  begin sz_ch = rd_reg.f32; sz_nx = rd_reg.q8; end
            SchQ8:   begin sz_ch = rd_reg.q8;  sz_nx = rd_reg.q4; end
            default: begin sz_ch = rd_reg.q4;  sz_nx = rd_reg.q4; end
        endcase
        dflt_ch = default_for_role(rd_reg.role);
        if (dflt_ch < rd_reg.cur) dflt_ch = rd_reg.cur;
        use_ch = (budget_reg == '0) ? dflt_ch : rd_reg.cur;
        case (use_ch)
            SchF32:  sz_use = rd_reg.f32;
            SchQ8:   sz_use = rd_reg.q8;
            default: sz_use = rd_reg.q4;
        endcase
        can_dn = (rd_ch_reg < SchQ4) && scheme_permitted(rd_reg.role, rd_ch_reg + 2'd1);
        save = {16'd0, sz_ch} - {16'd0, sz_nx};
    end

    logic [IdxW-1:0] rd_addr;
    logic            rd_en;
    logic [IdxW-1:0] wr_ch_addr;
    logic [1:0]      wr_ch_data;
    logic            wr_ch_en;
    always_comb begin
        rd_addr = ptr_reg[IdxW-1:0];
        rd_en = (state_reg == ST_SUM || state_reg == ST_SCAN || state_reg == ST_EMIT)
                && (ptr_reg < count_reg);
        wr_ch_en = 1'b0;
        wr_ch_addr = rd_idx_reg;
        wr_ch_data = use_ch;
        if (state_reg == ST_SUM && rd_valid_reg) begin
            wr_ch_en = 1'b1;
        end else if (state_reg == ST_APPLY) begin
            wr_ch_en = 1'b1;
            wr_ch_addr = best_idx_reg;
            wr_ch_data = best_ch_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !s_action && count_reg < CntW'(MaxEntries)) begin
            mem[count_reg[IdxW-1:0]] <= '{role: ld_role, f32: ld_f32, q8: s_bytes_q8,
                                          q4: s_bytes_q4, cur: ld_sch};
        end
        if (wr_ch_en) begin
            chosen_mem[wr_ch_addr] <= wr_ch_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
            rd_ch_reg <= chosen_mem[rd_addr];
        end
        rd_idx_reg <= rd_addr;
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // A result leaves only from a read made at the current pointer, so each entry is sent once.
    logic emit_now;
    assign emit_now = (state_reg == ST_EMIT) && (count_reg != '0) && rd_valid_reg && out_free
                      && (CntW'(rd_idx_reg) == ptr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            budget_reg <= '0;
            count_reg <= '0;
            cur_total_reg <= '0;
            min_total_reg <= '0;
            total_reg <= '0;
            ptr_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            best_found_reg <= 1'b0;
            steps_reg <= '0;
            ok_reg <= 1'b0;
        end else begin
            if (cfg_wr && paddr == RegBudget) begin
                budget_reg <= pwdata[47:0];
            end
            if (emit_now) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            rd_valid_reg <= rd_en;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_action) begin
                            if (count_reg < CntW'(MaxEntries)) begin
                                count_reg <= count_reg + 1'b1;
                                cur_total_reg <= cur_total_reg + {16'd0, s_stored_bytes};
                                min_total_reg <= min_total_reg + {16'd0, ld_min};
                            end
                        end else begin
                            ptr_reg <= '0;
                            total_reg <= '0;
                            steps_reg <= '0;
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    if (rd_en) ptr_reg <= ptr_reg + 1'b1;
                    if (rd_valid_reg) total_reg <= total_reg + {16'd0, sz_use};
                    if (!rd_en && !rd_valid_reg) state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    ptr_reg <= '0;
                    best_gain_reg <= '0;
                    best_found_reg <= 1'b0;
                    if (budget_reg != '0 && total_reg > {16'd0, budget_reg}
                        && steps_reg < 8'(2 * MaxEntries)) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        ok_reg <= (budget_reg == '0) || (total_reg <= {16'd0, budget_reg});
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SCAN: begin
                    if (rd_en) ptr_reg <= ptr_reg + 1'b1;
                    if (rd_valid_reg && can_dn
                        && (!best_found_reg || save > best_gain_reg)) begin
                        best_found_reg <= 1'b1;
                        best_gain_reg <= save;
                        best_idx_reg <= rd_idx_reg;
                        best_ch_reg <= rd_ch_reg;
                    end
                    if (!rd_en && !rd_valid_reg) begin
                        if (best_found_reg) begin
                            state_reg <= ST_APPLY;
                        end else begin
                            ok_reg <= total_reg <= {16'd0, budget_reg};
                            ptr_reg <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_APPLY: begin
                    total_reg <= total_reg - best_gain_reg;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= ST_CHECK;
                end
                ST_EMIT: begin
                    if (count_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else if (emit_now) begin
                        m_idx_reg <= 6'(rd_idx_reg);
                        m_cur_reg <= rd_reg.cur;
                        m_ch_reg <= rd_ch_reg;
                        m_plan_reg <= total_reg;
                        m_curt_reg <= cur_total_reg;
                        m_mint_reg <= min_total_reg;
                        m_feas_reg <= ok_reg;
                        m_last_reg <= (CntW'(rd_idx_reg) + 1'b1 == count_reg);
                        if (CntW'(rd_idx_reg) + 1'b1 == count_reg) begin
                            state_reg <= ST_IDLE;
                            ptr_reg <= '0;
                        end else begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        m_valid = m_valid_reg;
        m_tensor_index = m_idx_reg;
        m_current_scheme = m_cur_reg;
        m_chosen_scheme = m_ch_reg;
        m_planned_bytes = m_plan_reg;
        m_current_total = m_curt_reg;
        m_minimum_total = m_mint_reg;
        m_feasible = m_feas_reg;
        m_last = m_last_reg;
    end

    `ASSERT_CLK(a_busy_not_ready, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready, "ready while busy")
    `ASSERT_CLK(a_count_max, aclk, aresetn, count_reg <= CntW'(MaxEntries), "entry count overflow")
    `ASSERT_NEVER(a_out_idle, aclk, aresetn, $rose(m_valid_reg) && state_reg == ST_SUM, "result during sum")
endmodule
